>>> src/depth_pixel_backprojection_defines.svh
// Assertion macros shared by the back-projection RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dpb_pkg.sv
// Shared types, constants and width helpers for the depth back-projection pipeline.
// No dependencies; imported by every module of the block.
package dpb_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COORD_BITS_MAX = 13;
  localparam int DIV_STEPS      = 4;   // quotient bits resolved per divider stage
  localparam int Q_LO_W         = 26;  // low slice of the quotient for the pose multipliers
  localparam int ROUND_SHIFT    = 22;
  localparam int ROUND_HALF     = 1 << 21;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [15:0] DEPTH_MIN = 16'd10;
  localparam logic [15:0] DEPTH_MAX = 16'd10000;

  localparam logic signed [23:0] WORLD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] WORLD_MIN = 24'sh800000;

  localparam logic [15:0] FOCAL_X_RST  = 16'd8192;
  localparam logic [15:0] FOCAL_Y_RST  = 16'd8192;
  localparam logic [15:0] CENTER_X_RST = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST = 16'd3840;
  localparam logic [63:0] POSE_0_RST   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] POSE_1_RST   = 64'h0000_4000_0000_0000;
  localparam logic [63:0] POSE_2_RST   = 64'h0000_0000_4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_POSE_0   = 3'd4,
    CFG_POSE_1   = 3'd5,
    CFG_POSE_2   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] r0;
    logic signed [15:0] r1;
    logic signed [15:0] r2;
    logic signed [15:0] tr;
  } pose_row_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // Side data that rides along the x divider.
  typedef struct packed {
    logic        neg;
    logic [15:0] z;
    color_t      color;
  } xpay_t;

  function automatic int mag_width(input int cb);
    return (cb + 4 > 16) ? cb + 4 : 16;
  endfunction

  function automatic int dvd_width(input int cb);
    return mag_width(cb) + 25;
  endfunction

  // Base-4 digit sum, folded twice; 4 is 1 modulo 3.
  function automatic logic mult_of_3(input logic [COORD_BITS_MAX-1:0] v);
    logic [13:0] w;
    logic [4:0]  s1;
    logic [2:0]  s2;
    logic [2:0]  s3;
    w  = {1'b0, v};
    s1 = '0;
    for (int i = 0; i < 7; i++) begin
      s1 = s1 + 5'(w[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

endpackage

>>> src/dpb_front.sv
// Front end: grid and depth filter, centered offsets, depth products, rounded dividends.
// Three register stages; uses dpb_pkg.
module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [COORD_BITS-1:0]         in_row,
  input  logic [COORD_BITS-1:0]         in_col,
  input  logic [15:0]                   in_depth,
  input  color_t                        in_color,
  input  logic [15:0]                   center_x,
  input  logic [15:0]                   center_y,
  input  logic [15:0]                   fx_eff,
  input  logic [15:0]                   fy_eff,
  output logic                          out_vld,
  output logic [dvd_width(COORD_BITS)-1:0] out_dvd_x,
  output logic [dvd_width(COORD_BITS)-1:0] out_dvd_y,
  output xpay_t                         out_pay_x,
  output logic                          out_neg_y
);

  localparam int MAGW = mag_width(COORD_BITS);
  localparam int PRW  = MAGW + 16;
  localparam int DVW  = dvd_width(COORD_BITS);

  logic            pass;
  logic [MAGW-1:0] col16, row16, cxe, cye;

  logic            vld1_r, vld2_r, vld3_r;
  logic [MAGW-1:0] magx1_r, magy1_r;
  logic            negx1_r, negy1_r, negx2_r, negy2_r, negx3_r, negy3_r;
  logic [15:0]     z1_r, z2_r, z3_r;
  color_t          col1_r, col2_r, col3_r;
  logic [PRW-1:0]  prodx2_r, prody2_r;
  logic [DVW-1:0]  dvdx3_r, dvdy3_r;

  assign pass = mult_of_3(COORD_BITS_MAX'(in_row)) && mult_of_3(COORD_BITS_MAX'(in_col)) &&
                (in_depth >= DEPTH_MIN) && (in_depth <= DEPTH_MAX);

  assign col16 = MAGW'({in_col, 4'b0000});
  assign row16 = MAGW'({in_row, 4'b0000});
  assign cxe   = MAGW'(center_x);
  assign cye   = MAGW'(center_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld && pass;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Keep offsets as sign and magnitude; the sign is applied to the pose later.
  always_ff @(posedge clk) begin
    negx1_r <= col16 < cxe;
    negy1_r <= row16 < cye;
    magx1_r <= (col16 < cxe) ? cxe - col16 : col16 - cxe;
    magy1_r <= (row16 < cye) ? cye - row16 : row16 - cye;
    z1_r    <= in_depth;
    col1_r  <= in_color;

    prodx2_r <= PRW'(magx1_r) * PRW'(z1_r);
    prody2_r <= PRW'(magy1_r) * PRW'(z1_r);
    negx2_r  <= negx1_r;
    negy2_r  <= negy1_r;
    z2_r     <= z1_r;
    col2_r   <= col1_r;

    // Scale by 256 and add half the divisor for round-to-nearest.
    dvdx3_r <= DVW'({prodx2_r, 8'h00}) + DVW'(fx_eff[15:1]);
    dvdy3_r <= DVW'({prody2_r, 8'h00}) + DVW'(fy_eff[15:1]);
    negx3_r <= negx2_r;
    negy3_r <= negy2_r;
    z3_r    <= z2_r;
    col3_r  <= col2_r;
  end

  assign out_vld         = vld3_r;
  assign out_dvd_x       = dvdx3_r;
  assign out_dvd_y       = dvdy3_r;
  assign out_pay_x.neg   = negx3_r;
  assign out_pay_x.z     = z3_r;
  assign out_pay_x.color = col3_r;
  assign out_neg_y       = negy3_r;

endmodule

>>> src/dpb_div.sv
// Pipelined restoring divider by a 16-bit divisor, DIV_STEPS quotient bits per stage.
// Carries a side payload in step with the quotient; uses dpb_pkg and the assertion macros.
`include "depth_pixel_backprojection_defines.svh"
module dpb_div import dpb_pkg::*; #(
  parameter int DVW = dvd_width(COORD_BITS_DEF),
  parameter int PW  = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [DVW-1:0] in_dvd,
  input  logic [15:0]    divisor,
  input  logic [PW-1:0]  in_pay,
  output logic           out_vld,
  output logic [DVW-1:0] out_quo,
  output logic [PW-1:0]  out_pay
);

  localparam int NST  = (DVW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NPAD = NST * DIV_STEPS;

  logic            vld_r [NST];
  logic [15:0]     rem_r [NST];
  logic [NPAD-1:0] acc_r [NST];   // dividend bits shift out the top, quotient bits in the bottom
  logic [PW-1:0]   pay_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic            vld_in;
    logic [15:0]     rem_in;
    logic [NPAD-1:0] acc_in;
    logic [PW-1:0]   pay_in;
    logic [15:0]     rem_nxt;
    logic [NPAD-1:0] acc_nxt;

    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign acc_in = NPAD'(in_dvd);
      assign pay_in = in_pay;
    end else begin : g_rest
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign acc_in = acc_r[s-1];
      assign pay_in = pay_r[s-1];
    end

    always_comb begin : p_steps
      logic [16:0] trial;
      rem_nxt = rem_in;
      acc_nxt = acc_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {rem_nxt, acc_nxt[NPAD-1]};
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = 16'(trial - {1'b0, divisor});
          acc_nxt = {acc_nxt[NPAD-2:0], 1'b1};
        end else begin
          rem_nxt = trial[15:0];
          acc_nxt = {acc_nxt[NPAD-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      acc_r[s] <= acc_nxt;
      pay_r[s] <= pay_in;
    end
  end

  assign out_vld = vld_r[NST-1];
  assign out_quo = acc_r[NST-1][DVW-1:0];
  assign out_pay = pay_r[NST-1];

  `DPB_ASSERT_SAME(a_rem_below_divisor, vld_r[NST-1], rem_r[NST-1] < divisor, "divider remainder not below divisor")

endmodule

>>> src/dpb_xform.sv
// Camera-to-world transform: split pose products, row sums, rounding, translation, saturation.
// Five register stages over three lanes; uses dpb_pkg and the assertion macros.
`include "depth_pixel_backprojection_defines.svh"
module dpb_xform import dpb_pkg::*; #(
  parameter int QW = dvd_width(COORD_BITS_DEF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [QW-1:0]       in_qx,
  input  logic [QW-1:0]       in_qy,
  input  xpay_t               in_pay_x,
  input  logic                in_neg_y,
  input  pose_row_t           pose [3],
  output logic                out_vld,
  output logic signed [23:0]  out_world [3],
  output color_t              out_color
);

  localparam int QHW = QW - Q_LO_W;
  localparam int LW  = 17 + Q_LO_W + 1;
  localparam int HW  = 17 + QHW + 1;
  localparam int AW  = QW + 18;
  localparam int RW  = AW - ROUND_SHIFT;
  localparam int SW  = RW + 1;

  logic   vld_r [5];
  color_t col_r [5];

  logic signed [LW-1:0] pxl1_r [3];
  logic signed [HW-1:0] pxh1_r [3];
  logic signed [LW-1:0] pyl1_r [3];
  logic signed [HW-1:0] pyh1_r [3];
  logic signed [32:0]   pz1_r  [3];
  logic signed [AW-1:0] tx2_r  [3];
  logic signed [AW-1:0] ty2_r  [3];
  logic signed [AW-1:0] tz2_r  [3];
  logic signed [AW-1:0] acc3_r [3];
  logic signed [RW-1:0] rnd4_r [3];
  logic signed [23:0]   wld5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < 5; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    col_r[0] <= in_pay_x.color;
    for (int k = 1; k < 5; k++) col_r[k] <= col_r[k-1];
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [16:0]   rx, ry;
    logic signed [AW-1:0] bias;
    logic signed [AW-1:0] biased;
    logic signed [SW-1:0] moved;

    // Fold the offset sign into the rotation entry.
    assign rx = in_pay_x.neg ? -17'(pose[i].r0) : 17'(pose[i].r0);
    assign ry = in_neg_y     ? -17'(pose[i].r1) : 17'(pose[i].r1);

    // Ties away from zero: negative sums take one less bias before the floor shift.
    assign bias   = acc3_r[i][AW-1] ? AW'(ROUND_HALF - 1) : AW'(ROUND_HALF);
    assign biased = acc3_r[i] + bias;
    assign moved  = SW'(rnd4_r[i]) + SW'(pose[i].tr);

    always_ff @(posedge clk) begin
      pxl1_r[i] <= LW'(rx) * LW'($signed({1'b0, in_qx[Q_LO_W-1:0]}));
      pxh1_r[i] <= HW'(rx) * HW'($signed({1'b0, in_qx[QW-1:Q_LO_W]}));
      pyl1_r[i] <= LW'(ry) * LW'($signed({1'b0, in_qy[Q_LO_W-1:0]}));
      pyh1_r[i] <= HW'(ry) * HW'($signed({1'b0, in_qy[QW-1:Q_LO_W]}));
      pz1_r[i]  <= 33'(pose[i].r2) * 33'($signed({1'b0, in_pay_x.z}));

      tx2_r[i] <= (AW'(pxh1_r[i]) <<< Q_LO_W) + AW'(pxl1_r[i]);
      ty2_r[i] <= (AW'(pyh1_r[i]) <<< Q_LO_W) + AW'(pyl1_r[i]);
      tz2_r[i] <= AW'(pz1_r[i]) <<< 8;

      acc3_r[i] <= tx2_r[i] + ty2_r[i] + tz2_r[i];

      rnd4_r[i] <= RW'(biased >>> ROUND_SHIFT);

      if (moved > SW'(WORLD_MAX)) begin
        wld5_r[i] <= WORLD_MAX;
      end else if (moved < SW'(WORLD_MIN)) begin
        wld5_r[i] <= WORLD_MIN;
      end else begin
        wld5_r[i] <= 24'(moved);
      end
    end

    assign out_world[i] = wld5_r[i];

    `DPB_ASSERT_NEXT(a_round_keeps_sign, vld_r[2] && !acc3_r[i][AW-1], !rnd4_r[i][RW-1], "rounding turned a non-negative sum negative")
  end

  assign out_vld   = vld_r[4];
  assign out_color = col_r[4];

endmodule

>>> src/depth_pixel_backprojection.sv
// Depth pixel to world point back-projection, one pixel per clock while busy is low.
// Pipeline: dpb_front, then the x and y dividers (dpb_div) side by side, then dpb_xform to out_valid;
// the pipelined divider makes up most of the pipeline.
// Throughput: one pixel per cycle; busy only rises for reset and the cycle after it.
// Reset (rst_n low, synchronous) empties the pipeline and restores the default intrinsics and pose.
module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  input  logic [COORD_BITS-1:0] in_pixel_col,
  input  logic [15:0]           in_depth_mm,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  output logic                  out_valid,
  output logic signed [23:0]    out_world_x,
  output logic signed [23:0]    out_world_y,
  output logic signed [23:0]    out_world_z,
  output logic [7:0]            out_point_blue,
  output logic [7:0]            out_point_green,
  output logic [7:0]            out_point_red,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DVW = dvd_width(COORD_BITS);
  localparam int XPW = $bits(xpay_t);

  logic        busy_r;
  logic [15:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  pose_row_t   pose0_r, pose1_r, pose2_r;
  pose_row_t   pose [3];
  logic [15:0] fx_eff, fy_eff;
  logic        in_xfer;
  color_t      in_color;

  logic           fr_vld;
  logic [DVW-1:0] fr_dvd_x, fr_dvd_y;
  xpay_t          fr_pay_x;
  logic           fr_neg_y;

  logic           vld_x, vld_y;
  logic [DVW-1:0] quo_x, quo_y;
  logic [XPW-1:0] dpay_x;
  logic           dneg_y;

  logic signed [23:0] world [3];
  color_t             out_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_X_RST;
      focal_y_r  <= FOCAL_Y_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      pose0_r    <= pose_row_t'(POSE_0_RST);
      pose1_r    <= pose_row_t'(POSE_1_RST);
      pose2_r    <= pose_row_t'(POSE_2_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FOCAL_X:  focal_x_r  <= cfg_wdata[15:0];
        CFG_FOCAL_Y:  focal_y_r  <= cfg_wdata[15:0];
        CFG_CENTER_X: center_x_r <= cfg_wdata[15:0];
        CFG_CENTER_Y: center_y_r <= cfg_wdata[15:0];
        CFG_POSE_0:   pose0_r    <= pose_row_t'(cfg_wdata);
        CFG_POSE_1:   pose1_r    <= pose_row_t'(cfg_wdata);
        CFG_POSE_2:   pose2_r    <= pose_row_t'(cfg_wdata);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // A zero focal length divides as one.
  assign fx_eff = (focal_x_r == 16'd0) ? 16'd1 : focal_x_r;
  assign fy_eff = (focal_y_r == 16'd0) ? 16'd1 : focal_y_r;

  assign pose[0] = pose0_r;
  assign pose[1] = pose1_r;
  assign pose[2] = pose2_r;

  assign busy           = busy_r;
  assign in_xfer        = start && !busy_r;
  assign in_color.blue  = in_blue;
  assign in_color.green = in_green;
  assign in_color.red   = in_red;

  dpb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_xfer),
    .in_row    (in_pixel_row),
    .in_col    (in_pixel_col),
    .in_depth  (in_depth_mm),
    .in_color  (in_color),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .fx_eff    (fx_eff),
    .fy_eff    (fy_eff),
    .out_vld   (fr_vld),
    .out_dvd_x (fr_dvd_x),
    .out_dvd_y (fr_dvd_y),
    .out_pay_x (fr_pay_x),
    .out_neg_y (fr_neg_y)
  );

  dpb_div #(.DVW(DVW), .PW(XPW)) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_dvd  (fr_dvd_x),
    .divisor (fx_eff),
    .in_pay  (fr_pay_x),
    .out_vld (vld_x),
    .out_quo (quo_x),
    .out_pay (dpay_x)
  );

  dpb_div #(.DVW(DVW), .PW(1)) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_dvd  (fr_dvd_y),
    .divisor (fy_eff),
    .in_pay  (fr_neg_y),
    .out_vld (vld_y),
    .out_quo (quo_y),
    .out_pay (dneg_y)
  );

  dpb_xform #(.QW(DVW)) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld_x),
    .in_qx     (quo_x),
    .in_qy     (quo_y),
    .in_pay_x  (xpay_t'(dpay_x)),
    .in_neg_y  (dneg_y),
    .pose      (pose),
    .out_vld   (out_valid),
    .out_world (world),
    .out_color (out_color)
  );

  assign out_world_x     = world[0];
  assign out_world_y     = world[1];
  assign out_world_z     = world[2];
  assign out_point_blue  = out_color.blue;
  assign out_point_green = out_color.green;
  assign out_point_red   = out_color.red;

  `DPB_ASSERT_SAME(a_div_lockstep, 1'b1, vld_x == vld_y, "x and y dividers out of step")

endmodule
